@@ hw/rtl/ipcm_pkg.sv @@
// ipcm_pkg: shared types, register indexes and reset values for the ir pulse code matcher
// no dependencies; used by ipcm_decoder and ir_pulse_code_matcher

package ipcm_pkg;

  localparam int unsigned DefMaxFrameTicks = 100000;
  localparam int unsigned DefCodeBits      = 64;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned KEY_COUNT  = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  // a period longer than this before the first stored bit is a leader and gets skipped
  localparam logic [WIN_W-1:0] LEAD_SKIP_TICKS = 16'd4000;

  localparam logic [WIN_W-1:0] LONG_MIN_RST  = 16'd1500;
  localparam logic [WIN_W-1:0] LONG_MAX_RST  = 16'd1800;
  localparam logic [WIN_W-1:0] SHORT_MIN_RST = 16'd400;
  localparam logic [WIN_W-1:0] SHORT_MAX_RST = 16'd700;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_MIN   = 3'd0,
    CFG_LONG_MAX   = 3'd1,
    CFG_SHORT_MIN  = 3'd2,
    CFG_SHORT_MAX  = 3'd3,
    CFG_KEY_ONE    = 3'd4,
    CFG_KEY_TWO    = 3'd5,
    CFG_KEY_THREE  = 3'd6,
    CFG_POWER_CODE = 3'd7
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FRAME = 1'b1
  } frame_state_t;

  typedef struct packed {
    logic [WIN_W-1:0]                  long_min;
    logic [WIN_W-1:0]                  long_max;
    logic [WIN_W-1:0]                  short_min;
    logic [WIN_W-1:0]                  short_max;
    logic [KEY_COUNT-1:0][WORD_W-1:0]  key_code;
    logic [WORD_W-1:0]                 power_code;
  } cfg_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] leds;
    logic                 frame_done;
    logic [WORD_W-1:0]    frame_code;
    logic [LEN_W-1:0]     frame_length;
    logic [KEY_COUNT:0]   match_mask;
  } result_t;

endpackage

@@ hw/rtl/ipcm_decoder.sv @@
// ipcm_decoder: frame tracking, bit decode, code compare and led state for one sample a cycle while step is high
// depends on ipcm_pkg

module ipcm_decoder import ipcm_pkg::*; #(
  parameter int unsigned MAX_FRAME_TICKS = DefMaxFrameTicks,
  parameter int unsigned CODE_BITS       = DefCodeBits
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    level,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int unsigned FRAME_W = $clog2(MAX_FRAME_TICKS + 2);
  localparam int unsigned CMP_W   = (FRAME_W > WIN_W) ? FRAME_W : WIN_W;
  localparam int unsigned CNT_W   = $clog2(CODE_BITS + 1);
  localparam int unsigned IDX_W   = $clog2(CODE_BITS);

  frame_state_t            state, state_next;
  logic                    last_level;
  logic [FRAME_W-1:0]      frame_elapsed, frame_elapsed_next;
  logic [FRAME_W-1:0]      edge_elapsed, edge_elapsed_next;
  logic [CNT_W-1:0]        bit_count, bit_count_next;
  logic [CODE_BITS-1:0]    code_word, code_word_next;
  logic [KEY_COUNT-1:0]    led_levels, led_levels_next;

  logic                    level_edge, level_fall;
  logic [FRAME_W-1:0]      frame_inc, edge_inc;
  logic [CMP_W-1:0]        period;
  logic                    lead_skip, in_long, in_short, timeout, bad_period;
  logic                    store, end_frame, done;
  logic [CNT_W-1:0]        count_after;
  logic [CODE_BITS-1:0]    code_after;
  logic [WORD_W-1:0]       code_full;
  logic [KEY_COUNT-1:0]    key_hit, led_toggled, led_power;
  logic                    power_hit;

  // per-sample decode
  always_comb begin
    level_edge = level != last_level;
    level_fall = level_edge && !level;
    frame_inc  = frame_elapsed + FRAME_W'(1);
    edge_inc   = edge_elapsed + FRAME_W'(1);
    period     = CMP_W'(edge_inc);
    lead_skip  = (bit_count == '0) && (period > CMP_W'(LEAD_SKIP_TICKS));
    in_long    = (period >= CMP_W'(cfg.long_min)) && (period <= CMP_W'(cfg.long_max));
    in_short   = (period >= CMP_W'(cfg.short_min)) && (period <= CMP_W'(cfg.short_max));
    bad_period = level_edge && !lead_skip && !in_long && !in_short;
    timeout    = frame_inc > FRAME_W'(MAX_FRAME_TICKS);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (level_fall) state_next = ST_FRAME;
      end
      ST_FRAME: begin
        if (bad_period || timeout) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    end_frame = (state == ST_FRAME) && (state_next == ST_IDLE);
    store     = (state == ST_FRAME) && level_edge && !lead_skip && (in_long || in_short);

    count_after = bit_count;
    code_after  = code_word;
    if (store && (bit_count < CNT_W'(CODE_BITS))) begin
      count_after = bit_count + CNT_W'(1);
      // long window wins, so a bit is one only outside it
      if (!in_long) code_after = code_word | (CODE_BITS'(1) << bit_count[IDX_W-1:0]);
    end

    done      = end_frame && (count_after != '0);
    code_full = WORD_W'(code_after);
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_hit[k] = code_full == cfg.key_code[k];
    end
    power_hit   = code_full == cfg.power_code;
    led_toggled = led_levels ^ key_hit;
    led_power   = led_toggled[0] ? '0 : '1;

    led_levels_next = led_levels;
    if (done) led_levels_next = power_hit ? led_power : led_toggled;

    bit_count_next = end_frame ? '0 : count_after;
    code_word_next = end_frame ? '0 : code_after;

    frame_elapsed_next = frame_elapsed;
    edge_elapsed_next  = edge_elapsed;
    if (state == ST_IDLE) begin
      if (level_fall) begin
        frame_elapsed_next = '0;
        edge_elapsed_next  = '0;
      end
    end else begin
      frame_elapsed_next = frame_inc;
      edge_elapsed_next  = level_edge ? '0 : edge_inc;
    end

    result.leds         = led_levels_next;
    result.frame_done   = done;
    result.frame_code   = done ? code_full : '0;
    result.frame_length = done ? LEN_W'(count_after) : '0;
    result.match_mask   = done ? {power_hit, key_hit} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_level    <= 1'b0;
      frame_elapsed <= '0;
      edge_elapsed  <= '0;
      bit_count     <= '0;
      code_word     <= '0;
      led_levels    <= '0;
    end else if (step) begin
      state         <= state_next;
      last_level    <= level;
      frame_elapsed <= frame_elapsed_next;
      edge_elapsed  <= edge_elapsed_next;
      bit_count     <= bit_count_next;
      code_word     <= code_word_next;
      led_levels    <= led_levels_next;
    end
  end

  // frame timer never runs past one tick beyond the limit
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_elapsed <= FRAME_W'(MAX_FRAME_TICKS + 1))
    else $error("frame timer past limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(CODE_BITS))
    else $error("bit count past code width");

  // code and count are cleared whenever no frame is running
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (bit_count == '0) && (code_word == '0))
    else $error("stale code while idle");

endmodule

@@ hw/rtl/ir_pulse_code_matcher.sv @@
// ir_pulse_code_matcher: top level with config registers and the result skid stage
// depends on ipcm_pkg and ipcm_decoder

// usage
// - input channel: one receiver sample (ir_level) per transfer, in_valid / in_stall
// - output channel: exactly one result per input transfer, out_valid / out_stall;
//   led_one..led_three give the led levels after that sample, frame_done marks the
//   sample that closed a non-empty frame, with frame_code, frame_length, match_mask
// - config port: cfg_write with cfg_index / cfg_data writes one register in a cycle;
//   the user must write only while no sample is in flight, the block does not enforce it
// - result path: each result is registered in the output register or the skid entry
// - throughput: one sample per cycle while in_stall is low; decode, compare and led update
//   all finish in the cycle of the input transfer, in front of the output register
// - stall: an output register plus one skid entry; in_stall rises only once the
//   skid entry holds a result, so a sample can still be taken while the output waits
// - reset: windows return to 1500/1800/400/700 ticks, codes to zero, leds off,
//   decoder idle and both result slots empty; no clearing pass

module ir_pulse_code_matcher import ipcm_pkg::*; #(
  parameter int unsigned MAX_FRAME_TICKS = DefMaxFrameTicks,
  parameter int unsigned CODE_BITS       = DefCodeBits
) (
  input  logic                 clk,
  input  logic                 rst,
  // config port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // sample input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 ir_level,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 led_one,
  output logic                 led_two,
  output logic                 led_three,
  output logic                 frame_done,
  output logic [WORD_W-1:0]    frame_code,
  output logic [LEN_W-1:0]     frame_length,
  output logic [KEY_COUNT:0]   match_mask
);

  cfg_t    cfg;
  result_t new_result;
  result_t out_reg;
  result_t skid;
  logic    skid_valid;
  logic    in_take, out_take, out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_min   <= LONG_MIN_RST;
      cfg.long_max   <= LONG_MAX_RST;
      cfg.short_min  <= SHORT_MIN_RST;
      cfg.short_max  <= SHORT_MAX_RST;
      cfg.key_code   <= '0;
      cfg.power_code <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_LONG_MIN:   cfg.long_min    <= cfg_data[WIN_W-1:0];
        CFG_LONG_MAX:   cfg.long_max    <= cfg_data[WIN_W-1:0];
        CFG_SHORT_MIN:  cfg.short_min   <= cfg_data[WIN_W-1:0];
        CFG_SHORT_MAX:  cfg.short_max   <= cfg_data[WIN_W-1:0];
        CFG_KEY_ONE:    cfg.key_code[0] <= cfg_data;
        CFG_KEY_TWO:    cfg.key_code[1] <= cfg_data;
        CFG_KEY_THREE:  cfg.key_code[2] <= cfg_data;
        CFG_POWER_CODE: cfg.power_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;
  // registered stall: only a full skid entry holds off the sender
  assign in_stall = skid_valid;

  ipcm_decoder #(
    .MAX_FRAME_TICKS (MAX_FRAME_TICKS),
    .CODE_BITS       (CODE_BITS)
  ) u_decoder (
    .clk    (clk),
    .rst    (rst),
    .step   (in_take),
    .level  (ir_level),
    .cfg    (cfg),
    .result (new_result)
  );

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // skid drains first; no new transfer while it is full
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) out_reg <= skid;
    end else if (in_take) begin
      if (out_free) begin
        out_reg <= new_result;
      end else begin
        skid <= new_result;
      end
    end
  end

  assign led_one      = out_reg.leds[0];
  assign led_two      = out_reg.leds[1];
  assign led_three    = out_reg.leds[2];
  assign frame_done   = out_reg.frame_done;
  assign frame_code   = out_reg.frame_code;
  assign frame_length = out_reg.frame_length;
  assign match_mask   = out_reg.match_mask;

  // skid entry only fills behind a waiting output
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with empty output");

  // result fields are zero on samples that close no frame
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |->
      (frame_code == '0) && (frame_length == '0) && (match_mask == '0))
    else $error("frame fields set without frame_done");

  // a reported frame always holds at least one bit
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> frame_length != '0)
    else $error("empty frame reported");

endmodule
